// ===== src/nrs_pkg.sv =====
// ----------------------------------------------------------------------------
// nrs_pkg
// Shared types and constants for the nearest request scheduler: command
// codes, field widths and the pending map operation codes.
// ----------------------------------------------------------------------------
package nrs_pkg;

  // default sizing of the request table
  localparam int DEF_PAGES      = 256;
  localparam int DEF_WIDTH_BITS = 16;

  // fixed widths of the item fields
  localparam int CMD_BITS   = 2;
  localparam int PAGE_BITS  = 8;
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 9;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_TAKE    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_WINDOW  = 2'd2;

  // pending map operations
  typedef enum logic [1:0] {
    MAP_NOP,
    MAP_SET,
    MAP_CLR
  } map_op_t;

endpackage

// ===== src/nrs_width_mem.sv =====
// ----------------------------------------------------------------------------
// nrs_width_mem
// Request width table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nrs_width_mem #(
  parameter int DEPTH     = nrs_pkg::DEF_PAGES,
  parameter int DATA_BITS = nrs_pkg::DEF_WIDTH_BITS,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/nrs_map.sv =====
// ----------------------------------------------------------------------------
// nrs_map
// Pending map: one presence flag per page with a running count of pending
// requests. Set and clear adjust the count only when the flag changes.
// ----------------------------------------------------------------------------
module nrs_map #(
  parameter int PAGES = nrs_pkg::DEF_PAGES,
  localparam int IW   = $clog2(PAGES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nrs_pkg::map_op_t                op,
  input  logic [IW-1:0]                   idx,
  output logic                            hit,
  output logic [nrs_pkg::COUNT_BITS-1:0]  count
);
  import nrs_pkg::*;

  logic [PAGES-1:0]      map_r;
  logic [PAGES-1:0]      map_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;

  // flag at the addressed page
  assign hit   = map_r[idx];
  assign count = count_r;

  // set or clear one flag
  always_comb begin
    map_nxt   = map_r;
    count_nxt = count_r;
    case (op)
      MAP_SET: begin
        map_nxt[idx] = 1'b1;
        if (!hit) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
      MAP_CLR: begin
        map_nxt[idx] = 1'b0;
        if (hit) begin
          count_nxt = count_r - COUNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= '0;
      count_r <= '0;
    end else begin
      map_r   <= map_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== src/nearest_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// nearest_request_scheduler
// Pending request table with nearest-to-center selection and window pruning.
// ----------------------------------------------------------------------------
// Each item returns one result. An enqueue goes from EXEC to POST. A take and
// a pruning window command walk the pending map one page per cycle in SCAN. A
// take then goes through SELECT, FETCH and POST, or SELECT and POST when
// nothing is pending. A pruning window goes from SCAN to POST. A window with
// win_hi below win_lo only moves the center and goes from EXEC to POST. The
// input is stalled while an item is in work. A finished result sits in the
// output register, so the next item is accepted while it waits to be taken.
// The presence map resets at once; the width table needs no clearing.
// ----------------------------------------------------------------------------
module nearest_request_scheduler #(
  parameter int PAGES      = nrs_pkg::DEF_PAGES,
  parameter int WIDTH_BITS = nrs_pkg::DEF_WIDTH_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nrs_pkg::CMD_BITS-1:0]    in_command,
  input  logic [nrs_pkg::PAGE_BITS-1:0]   in_page,
  input  logic [nrs_pkg::FIELD_BITS-1:0]  in_width,
  input  logic [nrs_pkg::PAGE_BITS-1:0]   in_win_lo,
  input  logic [nrs_pkg::PAGE_BITS-1:0]   in_win_hi,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_picked,
  output logic [nrs_pkg::PAGE_BITS-1:0]   out_picked_page,
  output logic [nrs_pkg::FIELD_BITS-1:0]  out_picked_width,
  output logic [nrs_pkg::COUNT_BITS-1:0]  out_pending_count
);
  import nrs_pkg::*;

  localparam int IW = $clog2(PAGES);
  // compare width wide enough for index sums and twice the center
  localparam int CW = (IW + 1 > PAGE_BITS + 1) ? IW + 1 : PAGE_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SELECT,
    ST_FETCH,
    ST_POST
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_BITS-1:0]   cmd_r, cmd_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [FIELD_BITS-1:0] width_r, width_nxt;
  logic [PAGE_BITS-1:0]  kmin_r, kmin_nxt;
  logic [PAGE_BITS-1:0]  kmax_r, kmax_nxt;
  logic [PAGE_BITS-1:0]  center_r, center_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         lo_r, lo_nxt;
  logic [IW-1:0]         hi_r, hi_nxt;
  logic                  have_lo_r, have_lo_nxt;
  logic                  have_hi_r, have_hi_nxt;
  logic                  take_mode_r, take_mode_nxt;
  logic                  res_picked_r, res_picked_nxt;
  logic [PAGE_BITS-1:0]  res_page_r, res_page_nxt;
  logic [FIELD_BITS-1:0] res_width_r, res_width_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_picked_r, out_picked_nxt;
  logic [PAGE_BITS-1:0]  out_page_r, out_page_nxt;
  logic [FIELD_BITS-1:0] out_width_r, out_width_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;

  map_op_t               map_op;
  logic [IW-1:0]         map_idx;
  logic                  map_hit;
  logic [COUNT_BITS-1:0] map_count;
  logic                  mem_wr;
  logic                  mem_rd;
  logic [WIDTH_BITS-1:0] mem_rd_data;
  logic [IW-1:0]         sel;
  logic                  below_center;
  logic                  outside_window;
  logic                  page_in_range;

  // pending map and width table
  nrs_map #(.PAGES(PAGES)) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (map_op),
    .idx   (map_idx),
    .hit   (map_hit),
    .count (map_count)
  );

  nrs_width_mem #(.DEPTH(PAGES), .DATA_BITS(WIDTH_BITS)) u_width_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (IW'(page_r)),
    .wr_data (WIDTH_BITS'(width_r)),
    .rd_en   (mem_rd),
    .rd_addr (sel),
    .rd_data (mem_rd_data)
  );

  // shared compare unit of the scan
  assign below_center   = CW'(idx_r) < CW'(center_r);
  assign outside_window = (CW'(idx_r) < CW'(kmin_r)) || (CW'(idx_r) > CW'(kmax_r));
  assign page_in_range  = 32'(page_r) < 32'(PAGES);

  // nearest of the two candidates, upper one on a tie
  always_comb begin
    if (have_hi_r && have_lo_r) begin
      sel = ((CW'(hi_r) + CW'(lo_r)) <= (CW'(center_r) << 1)) ? hi_r : lo_r;
    end else if (have_hi_r) begin
      sel = hi_r;
    end else begin
      sel = lo_r;
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_picked        = out_picked_r;
  assign out_picked_page   = out_page_r;
  assign out_picked_width  = out_width_r;
  assign out_pending_count = out_count_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    width_nxt      = width_r;
    kmin_nxt       = kmin_r;
    kmax_nxt       = kmax_r;
    center_nxt     = center_r;
    idx_nxt        = idx_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    have_lo_nxt    = have_lo_r;
    have_hi_nxt    = have_hi_r;
    take_mode_nxt  = take_mode_r;
    res_picked_nxt = res_picked_r;
    res_page_nxt   = res_page_r;
    res_width_nxt  = res_width_r;
    out_valid_nxt  = out_valid_r;
    out_picked_nxt = out_picked_r;
    out_page_nxt   = out_page_r;
    out_width_nxt  = out_width_r;
    out_count_nxt  = out_count_r;
    map_op         = MAP_NOP;
    map_idx        = idx_r;
    mem_wr         = 1'b0;
    mem_rd         = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          page_nxt  = in_page;
          width_nxt = in_width;
          kmin_nxt  = in_win_lo;
          kmax_nxt  = in_win_hi;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_picked_nxt = 1'b0;
        res_page_nxt   = '0;
        res_width_nxt  = '0;
        state_nxt      = ST_POST;
        case (cmd_r)
          CMD_ENQUEUE: begin
            if (page_in_range) begin
              map_idx = IW'(page_r);
              map_op  = MAP_SET;
              mem_wr  = 1'b1;
            end
          end
          CMD_TAKE: begin
            idx_nxt       = '0;
            have_lo_nxt   = 1'b0;
            have_hi_nxt   = 1'b0;
            take_mode_nxt = 1'b1;
            state_nxt     = ST_SCAN;
          end
          CMD_WINDOW: begin
            center_nxt = PAGE_BITS'(((PAGE_BITS + 1)'(kmin_r) + (PAGE_BITS + 1)'(kmax_r)) >> 1);
            if (kmax_r >= kmin_r) begin
              idx_nxt       = '0;
              take_mode_nxt = 1'b0;
              state_nxt     = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        map_idx = idx_r;
        if (take_mode_r) begin
          // track last pending page below and first at or above the center
          if (map_hit) begin
            if (below_center) begin
              lo_nxt      = idx_r;
              have_lo_nxt = 1'b1;
            end else if (!have_hi_r) begin
              hi_nxt      = idx_r;
              have_hi_nxt = 1'b1;
            end
          end
        end else if (map_hit && outside_window) begin
          map_op = MAP_CLR;
        end
        if (idx_r == IW'(PAGES - 1)) begin
          state_nxt = take_mode_r ? ST_SELECT : ST_POST;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_SELECT: begin
        if (have_lo_r || have_hi_r) begin
          map_idx        = sel;
          map_op         = MAP_CLR;
          mem_rd         = 1'b1;
          res_picked_nxt = 1'b1;
          res_page_nxt   = PAGE_BITS'(sel);
          state_nxt      = ST_FETCH;
        end else begin
          state_nxt = ST_POST;
        end
      end
      ST_FETCH: begin
        res_width_nxt = FIELD_BITS'(mem_rd_data);
        state_nxt     = ST_POST;
      end
      ST_POST: begin
        // load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_picked_nxt = res_picked_r;
          out_page_nxt   = res_page_r;
          out_width_nxt  = res_width_r;
          out_count_nxt  = map_count;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      center_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      center_r    <= center_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    width_r      <= width_nxt;
    kmin_r       <= kmin_nxt;
    kmax_r       <= kmax_nxt;
    idx_r        <= idx_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    have_lo_r    <= have_lo_nxt;
    have_hi_r    <= have_hi_nxt;
    take_mode_r  <= take_mode_nxt;
    res_picked_r <= res_picked_nxt;
    res_page_r   <= res_page_nxt;
    res_width_r  <= res_width_nxt;
    out_picked_r <= out_picked_nxt;
    out_page_r   <= out_page_nxt;
    out_width_r  <= out_width_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
